// File: rtl/brrf_pkg.sv
// shared constants, field widths and state codes of the rectangle region finder
// no dependencies; used by the result interface and the top level
package brrf_pkg;

   // default sizes
   localparam int MAX_DIM_DEF     = 64;
   localparam int TABLE_DEPTH_DEF = 63;

   // field widths on the ports
   localparam int CFG_W   = 7;
   localparam int POS_W   = 6;
   localparam int DIM_W   = 7;
   localparam int AREA_W  = 13;
   localparam int COUNT_W = 12;
   localparam int IDX_W   = 1;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 12'd4095;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   // record kinds
   localparam logic KIND_REGION  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_LD,
      ST_COL,
      ST_MEAS,
      ST_REC,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_SEND,
      ST_SUM_SEND
   } state_type;

endpackage

// File: rtl/brrf_req_if.sv
// request channel: one pixel per request with the frame end mark
// depends on nothing
interface brrf_req_if;
   logic valid;
   logic ready;
   logic pixel;
   logic frame_end;

   modport source (output valid, output pixel, output frame_end, input ready);
   modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

// File: rtl/brrf_rsp_if.sv
// result channel: region records and the closing summary record
// depends on brrf_pkg for field widths
interface brrf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [brrf_pkg::POS_W-1:0]    start_row;
   logic [brrf_pkg::POS_W-1:0]    start_col;
   logic [brrf_pkg::DIM_W-1:0]    width;
   logic [brrf_pkg::DIM_W-1:0]    height;
   logic [brrf_pkg::AREA_W-1:0]   area;
   logic                          is_widest;
   logic                          is_tallest;
   logic                          is_largest;
   logic [brrf_pkg::COUNT_W-1:0]  region_count;
   logic                          overflow;
   logic                          last;

   modport source (output valid, output kind, output start_row, output start_col,
                   output width, output height, output area, output is_widest,
                   output is_tallest, output is_largest, output region_count,
                   output overflow, output last, input ready);
   modport sink   (input valid, input kind, input start_row, input start_col,
                   input width, input height, input area, input is_widest,
                   input is_tallest, input is_largest, input region_count,
                   input overflow, input last, output ready);
endinterface

// File: rtl/binary_rectangle_region_finder.sv
// Loading accepts one pixel request per cycle. After the frame end request the scan
// reads each row, tests each column for a corner and measures each corner's width along
// the row and its height down the rows, bounded by the row-wide pixel memory read port;
// then region records and the summary go out. No request is taken during scan/output.
// Synchronous reset clears control state and sets both dimensions to MAX_DIM; the pixel
// memory and region table are not cleared.
module binary_rectangle_region_finder #(
   parameter int MAX_DIM     = brrf_pkg::MAX_DIM_DEF,
   parameter int TABLE_DEPTH = brrf_pkg::TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   brrf_req_if.sink                    req,
   brrf_rsp_if.source                  rsp,
   input  logic                        csr_we,
   input  logic [brrf_pkg::IDX_W-1:0]  csr_index,
   input  logic [brrf_pkg::CFG_W-1:0]  csr_wdata
);
   import brrf_pkg::*;

   localparam int IW  = $clog2(MAX_DIM);
   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int AW  = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int TIW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TCW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [IW-1:0] row;
      logic [IW-1:0] col;
      logic [DW-1:0] w;
      logic [DW-1:0] h;
   } entry_type;

   // memories
   logic [MAX_DIM-1:0] pix_mem [MAX_DIM];
   entry_type          tbl_mem [TABLE_DEPTH];

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     rows_cfg_ff, cols_cfg_ff;
   logic [IW-1:0]        wr_row_ff, wr_row_in, wr_col_ff, wr_col_in;
   logic [IW-1:0]        r_ff, r_in, c_ff, c_in, wk_ff, wk_in, hk_ff, hk_in;
   logic [DW-1:0]        w_ff, w_in, h_ff, h_in;
   logic                 w_run_ff, w_run_in, h_run_ff, h_run_in, ph_ff, ph_in;
   logic [MAX_DIM-1:0]   cur_ff, cur_in, prev_ff, prev_in, pix_rd_ff;
   logic [COUNT_W-1:0]   found_ff, found_in;
   logic [TCW-1:0]       tcnt_ff, tcnt_in, k_ff, k_in;
   logic                 over_ff, over_in;
   logic [DW-1:0]        best_w_ff, best_w_in, best_h_ff, best_h_in;
   logic [AW-1:0]        best_a_ff, best_a_in;
   entry_type            tbl_rd_ff;

   // output register
   logic                 o_kind_ff, o_kind_in, o_last_ff, o_last_in;
   logic [POS_W-1:0]     o_row_ff, o_row_in, o_col_ff, o_col_in;
   logic [DIM_W-1:0]     o_w_ff, o_w_in, o_h_ff, o_h_in;
   logic [AREA_W-1:0]    o_a_ff, o_a_in;
   logic                 o_fw_ff, o_fw_in, o_fh_ff, o_fh_in, o_fa_ff, o_fa_in;
   logic [COUNT_W-1:0]   o_cnt_ff, o_cnt_in;
   logic                 o_ovf_ff, o_ovf_in;

   // memory control
   logic                 pix_we, pix_re, tbl_we, tbl_re;
   logic [IW-1:0]        pix_raddr;
   logic [TIW-1:0]       tbl_addr;
   entry_type            tbl_wdata;

   logic [DW-1:0]        nr, nc, col_p1, row_p1, c_p1, r_p1, wk_p1, hk_p1;
   logic [MAX_DIM-1:0]   left_v;
   logic                 corner, accept;
   logic [AW-1:0]        area_rec, area_out;

   // effective dimensions
   always_comb begin
      if (rows_cfg_ff == '0) nr = DW'(1);
      else if (int'(rows_cfg_ff) > MAX_DIM) nr = DW'(MAX_DIM);
      else nr = DW'(rows_cfg_ff);
      if (cols_cfg_ff == '0) nc = DW'(1);
      else if (int'(cols_cfg_ff) > MAX_DIM) nc = DW'(MAX_DIM);
      else nc = DW'(cols_cfg_ff);
   end

   assign accept   = req.valid && req.ready;
   assign col_p1   = DW'(wr_col_ff) + DW'(1);
   assign row_p1   = DW'(wr_row_ff) + DW'(1);
   assign c_p1     = DW'(c_ff) + DW'(1);
   assign r_p1     = DW'(r_ff) + DW'(1);
   assign wk_p1    = DW'(wk_ff) + DW'(1);
   assign hk_p1    = DW'(hk_ff) + DW'(1);
   assign left_v   = {cur_ff[MAX_DIM-2:0], 1'b0};
   assign corner   = cur_ff[c_ff] && !prev_ff[c_ff] && !left_v[c_ff];
   assign area_rec = AW'(w_ff) * AW'(h_ff);
   assign area_out = AW'(tbl_rd_ff.w) * AW'(tbl_rd_ff.h);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT_SEND) || (state_ff == ST_SUM_SEND);
   assign rsp.kind         = o_kind_ff;
   assign rsp.start_row    = o_row_ff;
   assign rsp.start_col    = o_col_ff;
   assign rsp.width        = o_w_ff;
   assign rsp.height       = o_h_ff;
   assign rsp.area         = o_a_ff;
   assign rsp.is_widest    = o_fw_ff;
   assign rsp.is_tallest   = o_fh_ff;
   assign rsp.is_largest   = o_fa_ff;
   assign rsp.region_count = o_cnt_ff;
   assign rsp.overflow     = o_ovf_ff;
   assign rsp.last         = o_last_ff;

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      wr_row_in = wr_row_ff;  wr_col_in = wr_col_ff;
      r_in = r_ff;  c_in = c_ff;  wk_in = wk_ff;  hk_in = hk_ff;
      w_in = w_ff;  h_in = h_ff;
      w_run_in = w_run_ff;  h_run_in = h_run_ff;  ph_in = ph_ff;
      cur_in = cur_ff;  prev_in = prev_ff;
      found_in = found_ff;  tcnt_in = tcnt_ff;  k_in = k_ff;  over_in = over_ff;
      best_w_in = best_w_ff;  best_h_in = best_h_ff;  best_a_in = best_a_ff;
      o_kind_in = o_kind_ff;  o_last_in = o_last_ff;
      o_row_in = o_row_ff;  o_col_in = o_col_ff;
      o_w_in = o_w_ff;  o_h_in = o_h_ff;  o_a_in = o_a_ff;
      o_fw_in = o_fw_ff;  o_fh_in = o_fh_ff;  o_fa_in = o_fa_ff;
      o_cnt_in = o_cnt_ff;  o_ovf_in = o_ovf_ff;
      pix_we = 1'b0;  pix_re = 1'b0;  pix_raddr = r_ff;
      tbl_we = 1'b0;  tbl_re = 1'b0;
      tbl_addr = TIW'(tcnt_ff);
      tbl_wdata = '{row: r_ff, col: c_ff, w: w_ff, h: h_ff};

      case (state_ff)
         // pixel load
         ST_IDLE: begin
            if (accept) begin
               pix_we = 1'b1;
               if (req.frame_end) begin
                  wr_row_in = '0;  wr_col_in = '0;
                  r_in = '0;  c_in = '0;  prev_in = '0;
                  found_in = '0;  tcnt_in = '0;  over_in = 1'b0;
                  best_w_in = '0;  best_h_in = '0;  best_a_in = '0;
                  state_in = ST_ROW_RD;
               end else begin
                  if (col_p1 >= nc) begin
                     wr_col_in = '0;
                     wr_row_in = (row_p1 >= nr) ? '0 : IW'(row_p1);
                  end else begin
                     wr_col_in = IW'(col_p1);
                     wr_row_in = (DW'(wr_row_ff) >= nr) ? '0 : wr_row_ff;
                  end
               end
            end
         end
         // fetch one image row
         ST_ROW_RD: begin
            pix_re = 1'b1;
            pix_raddr = r_ff;
            state_in = ST_ROW_LD;
         end
         ST_ROW_LD: begin
            cur_in = pix_rd_ff;
            c_in = '0;
            state_in = ST_COL;
         end
         // corner test and run measurement
         ST_COL, ST_REC: begin
            if (state_ff == ST_COL && corner) begin
               wk_in = c_ff;  hk_in = r_ff;
               w_in = DW'(1);  h_in = DW'(1);
               w_run_in = 1'b1;  h_run_in = 1'b1;  ph_in = 1'b0;
               state_in = ST_MEAS;
            end else begin
               if (state_ff == ST_REC) begin
                  if (found_ff != COUNT_LIMIT) found_in = found_ff + COUNT_W'(1);
                  if (int'(tcnt_ff) < TABLE_DEPTH) begin
                     tbl_we = 1'b1;
                     tcnt_in = tcnt_ff + TCW'(1);
                  end else begin
                     over_in = 1'b1;
                  end
                  if (w_ff > best_w_ff) best_w_in = w_ff;
                  if (h_ff > best_h_ff) best_h_in = h_ff;
                  if (area_rec > best_a_ff) best_a_in = area_rec;
               end
               if (c_p1 < nc) begin
                  c_in = IW'(c_p1);
                  state_in = ST_COL;
               end else begin
                  prev_in = cur_ff;
                  c_in = '0;
                  if (r_p1 < nr) begin
                     r_in = IW'(r_p1);
                     state_in = ST_ROW_RD;
                  end else begin
                     k_in = '0;
                     state_in = ST_OUT_RD;
                  end
               end
            end
         end
         ST_MEAS: begin
            if (w_run_ff) begin
               if (wk_p1 < nc && cur_ff[wk_p1[IW-1:0]]) begin
                  wk_in = wk_p1[IW-1:0];
                  w_in = w_ff + DW'(1);
               end else begin
                  w_run_in = 1'b0;
               end
            end
            if (h_run_ff) begin
               if (!ph_ff) begin
                  if (hk_p1 < nr) begin
                     pix_re = 1'b1;
                     pix_raddr = hk_p1[IW-1:0];
                     ph_in = 1'b1;
                  end else begin
                     h_run_in = 1'b0;
                  end
               end else begin
                  ph_in = 1'b0;
                  if (pix_rd_ff[c_ff]) begin
                     hk_in = hk_p1[IW-1:0];
                     h_in = h_ff + DW'(1);
                  end else begin
                     h_run_in = 1'b0;
                  end
               end
            end
            if (!w_run_ff && !h_run_ff) state_in = ST_REC;
         end
         // region records, then the summary
         ST_OUT_RD: begin
            if (k_ff < tcnt_ff) begin
               tbl_re = 1'b1;
               tbl_addr = TIW'(k_ff);
               state_in = ST_OUT_LD;
            end else begin
               o_kind_in = KIND_SUMMARY;  o_last_in = 1'b1;
               o_row_in = '0;  o_col_in = '0;
               o_w_in = DIM_W'(best_w_ff);  o_h_in = DIM_W'(best_h_ff);
               o_a_in = AREA_W'(best_a_ff);
               o_fw_in = 1'b0;  o_fh_in = 1'b0;  o_fa_in = 1'b0;
               o_cnt_in = found_ff;  o_ovf_in = over_ff;
               state_in = ST_SUM_SEND;
            end
         end
         ST_OUT_LD: begin
            o_kind_in = KIND_REGION;  o_last_in = 1'b0;
            o_row_in = POS_W'(tbl_rd_ff.row);  o_col_in = POS_W'(tbl_rd_ff.col);
            o_w_in = DIM_W'(tbl_rd_ff.w);  o_h_in = DIM_W'(tbl_rd_ff.h);
            o_a_in = AREA_W'(area_out);
            o_fw_in = (tbl_rd_ff.w == best_w_ff);
            o_fh_in = (tbl_rd_ff.h == best_h_ff);
            o_fa_in = (area_out == best_a_ff);
            o_cnt_in = '0;  o_ovf_in = 1'b0;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp.ready) begin
               k_in = k_ff + TCW'(1);
               state_in = ST_OUT_RD;
            end
         end
         ST_SUM_SEND: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rows_cfg_ff <= CFG_W'(MAX_DIM);
         cols_cfg_ff <= CFG_W'(MAX_DIM);
         wr_row_ff   <= '0;
         wr_col_ff   <= '0;
         found_ff    <= '0;
         tcnt_ff     <= '0;
         over_ff     <= 1'b0;
         best_w_ff   <= '0;
         best_h_ff   <= '0;
         best_a_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         wr_row_ff <= wr_row_in;
         wr_col_ff <= wr_col_in;
         found_ff  <= found_in;
         tcnt_ff   <= tcnt_in;
         over_ff   <= over_in;
         best_w_ff <= best_w_in;
         best_h_ff <= best_h_in;
         best_a_ff <= best_a_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_COUNT: rows_cfg_ff <= csr_wdata;
               CSR_COL_COUNT: cols_cfg_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      r_ff <= r_in;  c_ff <= c_in;  wk_ff <= wk_in;  hk_ff <= hk_in;
      w_ff <= w_in;  h_ff <= h_in;
      w_run_ff <= w_run_in;  h_run_ff <= h_run_in;  ph_ff <= ph_in;
      cur_ff <= cur_in;  prev_ff <= prev_in;  k_ff <= k_in;
      o_kind_ff <= o_kind_in;  o_last_ff <= o_last_in;
      o_row_ff <= o_row_in;  o_col_ff <= o_col_in;
      o_w_ff <= o_w_in;  o_h_ff <= o_h_in;  o_a_ff <= o_a_in;
      o_fw_ff <= o_fw_in;  o_fh_ff <= o_fh_in;  o_fa_ff <= o_fa_in;
      o_cnt_ff <= o_cnt_in;  o_ovf_ff <= o_ovf_in;
   end

   // pixel memory: single bit write, row-wide registered read
   always_ff @(posedge clock) begin
      if (pix_we) pix_mem[wr_row_ff][wr_col_ff] <= req.pixel;
      if (pix_re) pix_rd_ff <= pix_mem[pix_raddr];
   end

   // region table memory
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
      if (tbl_re) tbl_rd_ff <= tbl_mem[tbl_addr];
   end

endmodule
